[src/range_sum_segment_tree_top_assert.svh]
// Assertion macros for the range-sum segment tree block.
`ifndef RANGE_SUM_SEGMENT_TREE_TOP_ASSERT_SVH
`define RANGE_SUM_SEGMENT_TREE_TOP_ASSERT_SVH
`ifndef SYNTH
// Same-cycle implication, checked on every rising clock edge outside reset.
`define RSST_ASSERT_IMPL(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("rsst: same-cycle check failed");
// Next-cycle implication, checked on every rising clock edge outside reset.
`define RSST_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("rsst: next-cycle check failed");
`else
`define RSST_ASSERT_IMPL(lbl, ante, cons)
`define RSST_ASSERT_NEXT(lbl, ante, cons)
`endif
`endif

[src/rsst_pkg.sv]
// Package with sizes, codes and state type of the range-sum segment tree.
package rsst_pkg;

  // Tree geometry: LEAVES leaves, node indexes 1 .. 2*LEAVES-1.
  localparam int unsigned LEAVES = 1024;
  localparam int unsigned POS_W  = $clog2(LEAVES);
  localparam int unsigned NODE_W = $clog2(2 * LEAVES);
  localparam int unsigned SUM_W  = 64;

  typedef logic [NODE_W-1:0] node_idx_t;
  // Walk pointers need one more bit, since the right bound can reach 2*LEAVES.
  typedef logic [NODE_W:0]   walk_t;
  typedef logic [SUM_W-1:0]  sum_t;

  // Action codes.
  localparam logic ACT_SET   = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SET_RD,
    ST_SET_WR,
    ST_UPD_RD,
    ST_UPD_WR,
    ST_Q_LOOP,
    ST_Q_L_ACC,
    ST_Q_R_ACC
  } state_e;

endpackage

[src/rsst_if.sv]
// Valid/ready channel interfaces for actions in and range sums out.

interface rsst_in_if import rsst_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              action;
  logic [POS_W-1:0]  position;
  logic [SUM_W-1:0]  new_value;
  logic [POS_W-1:0]  range_low;
  logic [POS_W-1:0]  range_high;

  modport source (output valid, action, position, new_value, range_low, range_high,
                  input ready);
  modport sink   (input valid, action, position, new_value, range_low, range_high,
                  output ready);
endinterface

interface rsst_out_if import rsst_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [SUM_W-1:0]  range_sum;

  modport source (output valid, range_sum, input ready);
  modport sink   (input valid, range_sum, output ready);
endinterface

[src/range_sum_segment_tree_top.sv]
// Range-sum segment tree over 1024 positions with point set and range query.
//
// After reset the block sweeps its 2048-entry node memory to zero, one entry
// a cycle, and it accepts no action until that sweep is done.
// A set action reads the old leaf, writes the new one and then adds the
// difference into each of the 10 ancestors, a read state and then a write
// state for each tree level, through the single 64-bit adder and the single
// read port of the node memory. A query walks the left and right bounds up
// the tree (one node read for each odd bound, with the shift folded into the
// last step of each level). The block is ready again in the cycle after an
// action ends, so it takes no new action while a set or query is still in
// progress. A query result sits in an output register, so the next action
// is accepted while it waits; a query that finishes while the previous sum
// is still unread holds until that beat leaves.
// Sums wrap modulo 2^64.

module range_sum_segment_tree_top import rsst_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  rsst_in_if.sink    in_i,
  rsst_out_if.source res_o
);

  state_e    state_q, state_d;
  node_idx_t clr_cnt_q, clr_cnt_d;
  node_idx_t n_q, n_d;
  walk_t     l_q, l_d;
  walk_t     r_q, r_d;
  sum_t      acc_q, acc_d;
  sum_t      diff_q, diff_d;
  sum_t      val_q, val_d;
  sum_t      out_sum_q, out_sum_d;
  logic      out_valid_q, out_valid_d;
  sum_t      rdata_q;

  // Node memory port signals.
  logic      mem_we;
  node_idx_t mem_waddr;
  sum_t      mem_wdata;
  node_idx_t mem_raddr;
  sum_t      mem_q [2*LEAVES];

  // Shared adder operands.
  sum_t      add_a, add_b, add_sum;
  logic      add_sub;

  logic      in_acc;
  logic      q_done;
  logic      out_free;
  logic      out_load;
  walk_t     l_inc;

  assign in_acc   = in_i.valid && in_i.ready;
  assign q_done   = (l_q >= r_q);
  assign out_free = !out_valid_q || res_o.ready;
  assign l_inc    = l_q + walk_t'(1);

  // The one adder: subtract for the set difference, add everywhere else.
  assign add_sum = add_a + (add_sub ? ~add_b : add_b) + {{(SUM_W-1){1'b0}}, add_sub};

  // Node memory: one write and one registered read per cycle.
  always_ff @(posedge clk_i) begin
    if (mem_we) begin
      mem_q[mem_waddr] <= mem_wdata;
    end
    rdata_q <= mem_q[mem_raddr];
  end

  // Next state.
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_CLEAR: begin
        if (clr_cnt_q == '1) state_d = ST_IDLE;
      end
      ST_IDLE: begin
        if (in_acc) begin
          state_d = (in_i.action == ACT_SET) ? ST_SET_RD : ST_Q_LOOP;
        end
      end
      ST_SET_RD: state_d = ST_SET_WR;
      ST_SET_WR: state_d = ST_UPD_RD;
      ST_UPD_RD: state_d = ST_UPD_WR;
      ST_UPD_WR: begin
        state_d = ((n_q >> 1) == '0) ? ST_IDLE : ST_UPD_RD;
      end
      ST_Q_LOOP: begin
        if (q_done) begin
          if (out_free) state_d = ST_IDLE;
        end else if (l_q[0]) begin
          state_d = ST_Q_L_ACC;
        end else if (r_q[0]) begin
          state_d = ST_Q_R_ACC;
        end
      end
      ST_Q_L_ACC: state_d = r_q[0] ? ST_Q_R_ACC : ST_Q_LOOP;
      ST_Q_R_ACC: state_d = ST_Q_LOOP;
      default:    state_d = ST_IDLE;
    endcase
  end

  // Datapath control, memory access and operand selection.
  always_comb begin
    clr_cnt_d = clr_cnt_q;
    n_d       = n_q;
    l_d       = l_q;
    r_d       = r_q;
    acc_d     = acc_q;
    diff_d    = diff_q;
    val_d     = val_q;
    mem_we    = 1'b0;
    mem_waddr = n_q;
    mem_wdata = add_sum;
    mem_raddr = n_q;
    add_a     = acc_q;
    add_b     = rdata_q;
    add_sub   = 1'b0;
    out_load  = 1'b0;
    in_i.ready = 1'b0;
    unique case (state_q)
      ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_cnt_q;
        mem_wdata = '0;
        clr_cnt_d = clr_cnt_q + node_idx_t'(1);
      end
      ST_IDLE: begin
        in_i.ready = 1'b1;
        if (in_acc) begin
          n_d   = node_idx_t'(LEAVES) + node_idx_t'(in_i.position);
          val_d = in_i.new_value;
          l_d   = walk_t'(LEAVES) + walk_t'(in_i.range_low);
          r_d   = walk_t'(LEAVES) + walk_t'(in_i.range_high) + walk_t'(1);
          acc_d = '0;
        end
      end
      ST_SET_RD: begin
        mem_raddr = n_q;
      end
      ST_SET_WR: begin
        // Difference of new and old leaf, then the leaf itself.
        add_a     = val_q;
        add_b     = rdata_q;
        add_sub   = 1'b1;
        diff_d    = add_sum;
        mem_we    = 1'b1;
        mem_waddr = n_q;
        mem_wdata = val_q;
        n_d       = n_q >> 1;
      end
      ST_UPD_RD: begin
        mem_raddr = n_q;
      end
      ST_UPD_WR: begin
        add_a     = rdata_q;
        add_b     = diff_q;
        mem_we    = 1'b1;
        mem_waddr = n_q;
        mem_wdata = add_sum;
        n_d       = n_q >> 1;
      end
      ST_Q_LOOP: begin
        if (q_done) begin
          out_load = out_free;
        end else if (l_q[0]) begin
          mem_raddr = l_q[NODE_W-1:0];
        end else if (r_q[0]) begin
          mem_raddr = {r_q[NODE_W-1:1], 1'b0};
        end else begin
          l_d = l_q >> 1;
          r_d = r_q >> 1;
        end
      end
      ST_Q_L_ACC: begin
        acc_d = add_sum;
        if (r_q[0]) begin
          l_d       = l_inc;
          mem_raddr = {r_q[NODE_W-1:1], 1'b0};
        end else begin
          l_d = l_inc >> 1;
          r_d = r_q >> 1;
        end
      end
      ST_Q_R_ACC: begin
        acc_d = add_sum;
        l_d   = l_q >> 1;
        r_d   = r_q >> 1;
      end
      default: begin
      end
    endcase
  end

  // Output register for the range sum beat.
  always_comb begin
    out_valid_d = out_valid_q;
    out_sum_d   = out_sum_q;
    if (out_load) begin
      out_valid_d = 1'b1;
      out_sum_d   = acc_q;
    end else if (res_o.ready) begin
      out_valid_d = 1'b0;
    end
  end

  assign res_o.valid     = out_valid_q;
  assign res_o.range_sum = out_sum_q;

  // Control registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      clr_cnt_q   <= '0;
      out_valid_q <= 1'b0;
      n_q         <= '0;
      l_q         <= '0;
      r_q         <= '0;
    end else begin
      state_q     <= state_d;
      clr_cnt_q   <= clr_cnt_d;
      out_valid_q <= out_valid_d;
      n_q         <= n_d;
      l_q         <= l_d;
      r_q         <= r_d;
    end
  end

  // Payload registers.
  always_ff @(posedge clk_i) begin
    acc_q     <= acc_d;
    diff_q    <= diff_d;
    val_q     <= val_d;
    out_sum_q <= out_sum_d;
  end

`include "range_sum_segment_tree_top_assert.svh"

  // Node zero is unused: only the clearing sweep may write it.
  `RSST_ASSERT_IMPL(a_no_node0_write, mem_we && (state_q != ST_CLEAR), mem_waddr != '0)
  // The leaf write always targets the leaf half of the memory.
  `RSST_ASSERT_IMPL(a_leaf_index, state_q == ST_SET_WR, n_q[NODE_W-1])
  // Each ancestor write moves the walk one level toward the root.
  `RSST_ASSERT_NEXT(a_walk_up, state_q == ST_UPD_WR, n_q == ($past(n_q) >> 1))
  // The right bound of a query never passes one beyond the last node.
  `RSST_ASSERT_IMPL(a_r_bound, state_q == ST_Q_LOOP, r_q <= walk_t'(2 * LEAVES))

endmodule
